@@ design/ndt_pkg.sv @@
// Shared types, constants and name helper for the name directory table.
package ndt_pkg;

  localparam int DIR_ENTRIES = 16;
  localparam int NAME_BYTES  = 8;
  localparam int NUM_SECTORS = 1024;

  localparam int IDX_W    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int NAME_W   = 64;
  localparam int SECTOR_W = 10;
  localparam int LINK_W   = 11;
  localparam int SLOT_W   = 5;
  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 4;

  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;
  localparam logic [LINK_W-1:0] VAL_NONE  = '1;

  typedef enum logic [CMD_W-1:0] {
    OP_FIND    = 3'd0,
    OP_ADD     = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_SETLINK = 3'd3,
    OP_GETLINK = 3'd4,
    OP_READ    = 3'd5
  } ndt_op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_NONE = 2'd3
  } ndt_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ndt_state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [NAME_W-1:0]   name;
    logic [SECTOR_W-1:0] sector;
    logic                isdir;
    logic [INDEX_W-1:0]  index;
  } ndt_bcast_t;

  // Running result handed from one cell to the next.
  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    hit_slot;
    logic                free;
    logic [IDX_W-1:0]    free_slot;
    logic [SECTOR_W-1:0] sector;
    logic [LINK_W-1:0]   link;
    logic                rd_used;
    logic [NAME_W-1:0]   rd_name;
  } ndt_chain_t;

  // Zero every byte from the first zero byte on, and beyond NAME_BYTES.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

@@ design/name_directory_table.sv @@
// Top level of the name directory table: command control and the row of entry cells.
//
// Usage: drive cmd, entry_name, sector_in, is_directory and entry_index with
// start high; the beat is taken at a clock edge where busy is low. Commands
// are find, add, remove, set link, get link and read by index.
// Each entry is one cell in a row; the command is broadcast to all cells and
// a first-match / first-free chain runs combinationally from cell 0 upward, so
// the lowest matching or free entry wins and is written at the end of the chain cycle.
// The result is registered in the chain cycle and shown with done high
// for exactly one cycle; status, slot, value, name_out and slot_in_use are
// valid only in that cycle. A new command is taken only once the chain
// cycle of the last is over; busy is high for the chain cycle only, so
// the next start may land while done is high.
// The receiver cannot stall: a result not taken in its done cycle is gone.
// Reset (rst, synchronous) marks every entry unused and returns to idle;
// no clearing pass is needed, entry contents are read only once written.
module name_directory_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  cmd,
  input  logic [63:0] entry_name,
  input  logic [9:0]  sector_in,
  input  logic        is_directory,
  input  logic [3:0]  entry_index,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic [10:0] value,
  output logic [63:0] name_out,
  output logic        slot_in_use
);
  import ndt_pkg::*;

  ndt_state_t state;
  ndt_state_t state_next;
  logic       exec;
  logic       accept;
  ndt_bcast_t bc;

  ndt_chain_t             chain [DIR_ENTRIES+1];
  ndt_chain_t             tail;
  logic [DIR_ENTRIES-1:0] wr_vec;

  ndt_status_t       status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [LINK_W-1:0] value_next;
  logic [NAME_W-1:0] name_out_next;
  logic              slot_in_use_next;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state)
      S_IDLE: busy = 1'b0;
      S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
    end
  end

  // Hold the command for the chain cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      bc.op     <= cmd;
      bc.name   <= canon_name(entry_name);
      bc.sector <= sector_in;
      bc.isdir  <= is_directory;
      bc.index  <= entry_index;
    end
  end

  assign chain[0] = '0;
  assign tail     = chain[DIR_ENTRIES];

  for (genvar g = 0; g < DIR_ENTRIES; g++) begin : g_cell
    ndt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .exec    (exec),
      .bc      (bc),
      .my_idx  (IDX_W'(g)),
      .any_hit (tail.hit),
      .cin     (chain[g]),
      .cout    (chain[g+1]),
      .wr      (wr_vec[g])
    );
  end

  always_comb begin
    status_next      = STAT_NONE;
    slot_next        = SLOT_NONE;
    value_next       = '0;
    name_out_next    = '0;
    slot_in_use_next = 1'b0;
    unique case (bc.op)
      OP_FIND: begin
        value_next = VAL_NONE;
        if (tail.hit) begin
          status_next = STAT_OK;
          slot_next   = SLOT_W'(tail.hit_slot);
          value_next  = LINK_W'(tail.sector);
        end
      end
      OP_ADD: begin
        if (tail.hit) begin
          status_next = STAT_DUP;
          slot_next   = SLOT_W'(tail.hit_slot);
        end else if (tail.free) begin
          status_next = STAT_OK;
          slot_next   = SLOT_W'(tail.free_slot);
        end else begin
          status_next = STAT_FULL;
        end
      end
      OP_REMOVE, OP_SETLINK: begin
        if (tail.hit) begin
          status_next = STAT_OK;
          slot_next   = SLOT_W'(tail.hit_slot);
        end
      end
      OP_GETLINK: begin
        value_next = VAL_NONE;
        if (tail.hit) begin
          status_next = STAT_OK;
          slot_next   = SLOT_W'(tail.hit_slot);
          value_next  = tail.link;
        end
      end
      OP_READ: begin
        if (32'(bc.index) < DIR_ENTRIES) begin
          slot_next = SLOT_W'(bc.index);
          if (tail.rd_used) begin
            status_next      = STAT_OK;
            slot_in_use_next = 1'b1;
            name_out_next    = tail.rd_name;
          end
        end
      end
      default: status_next = STAT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status      <= status_next;
      slot        <= slot_next;
      value       <= value_next;
      name_out    <= name_out_next;
      slot_in_use <= slot_in_use_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without a chain cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC) && busy)
    else $error("accepted command did not enter the chain cycle");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_vec))
    else $error("more than one entry written by one command");

  a_write_only_exec: assert property (@(posedge clk) disable iff (rst)
    (wr_vec != '0) |-> exec)
    else $error("entry written outside the chain cycle");

  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_FULL) |-> (slot == SLOT_NONE))
    else $error("table full result carries a slot");
`endif

endmodule

@@ design/ndt_cell.sv @@
// One directory entry: storage, name compare and its link in the lookup chain.
module ndt_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           exec,
  input  ndt_pkg::ndt_bcast_t            bc,
  input  logic [ndt_pkg::IDX_W-1:0]      my_idx,
  input  logic                           any_hit,
  input  ndt_pkg::ndt_chain_t            cin,
  output ndt_pkg::ndt_chain_t            cout,
  output logic                           wr
);
  import ndt_pkg::*;

  logic                used;
  logic [NAME_W-1:0]   name;
  logic [SECTOR_W-1:0] sector;
  logic                isdir;
  logic [LINK_W-1:0]   link;

  logic match;
  logic first_hit;
  logic first_free;
  logic rd_sel;
  logic do_add;
  logic do_remove;
  logic do_setlink;

  assign match      = used && (name == bc.name);
  assign first_hit  = match && !cin.hit;
  assign first_free = !used && !cin.free;
  assign rd_sel     = (32'(bc.index) == 32'(my_idx)) && used;

  // Add waits on the whole chain: a later cell may still hold the name.
  assign do_add     = exec && (bc.op == OP_ADD) && !any_hit && first_free;
  assign do_remove  = exec && (bc.op == OP_REMOVE) && first_hit;
  assign do_setlink = exec && (bc.op == OP_SETLINK) && first_hit;
  assign wr         = do_add || do_remove || do_setlink;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (do_add) begin
      used <= 1'b1;
    end else if (do_remove) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      name   <= bc.name;
      sector <= bc.sector;
      isdir  <= bc.isdir;
      link   <= VAL_NONE;
    end else if (do_setlink) begin
      link <= LINK_W'(bc.sector);
    end
  end

  always_comb begin
    cout.hit       = cin.hit || match;
    cout.hit_slot  = cin.hit_slot | (first_hit ? my_idx : '0);
    cout.free      = cin.free || !used;
    cout.free_slot = cin.free_slot | (first_free ? my_idx : '0);
    cout.sector    = cin.sector | (first_hit ? sector : '0);
    cout.link      = cin.link | ((first_hit && !isdir) || first_hit ? link : '0);
    cout.rd_used   = cin.rd_used || rd_sel;
    cout.rd_name   = cin.rd_name | (rd_sel ? name : '0);
  end

endmodule

@@ tb/sv/name_directory_table_test.sv @@
// Self-checking testbench for the name directory table: directed and random commands.
module name_directory_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ndt_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int POOL_SIZE   = 20;
  localparam int RANDOM_CMDS = 950;
  localparam int STALL_LIMIT = 400;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] name;
    logic [9:0]  sector;
    logic        isdir;
    logic [3:0]  index;
    int          idle;
    bit          drain;
  } dir_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [10:0] value;
    logic [63:0] name;
    logic        in_use;
  } dir_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic [2:0]  cmd = '0;
  logic [63:0] entry_name = '0;
  logic [9:0]  sector_in = '0;
  logic        is_directory = 1'b0;
  logic [3:0]  entry_index = '0;
  logic [1:0]  status;
  logic [4:0]  slot;
  logic [10:0] value;
  logic [63:0] name_out;
  logic        slot_in_use;

  name_directory_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .cmd(cmd),
    .entry_name(entry_name),
    .sector_in(sector_in),
    .is_directory(is_directory),
    .entry_index(entry_index),
    .status(status),
    .slot(slot),
    .value(value),
    .name_out(name_out),
    .slot_in_use(slot_in_use)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Table as the testbench believes it to be.
  logic        tbl_used   [DIR_ENTRIES];
  logic [63:0] tbl_name   [DIR_ENTRIES];
  logic [9:0]  tbl_sector [DIR_ENTRIES];
  logic [10:0] tbl_link   [DIR_ENTRIES];

  dir_cmd_t   pending_cmds[$];
  dir_reply_t awaited_replies[$];
  dir_cmd_t   cur_cmd;

  int  errors = 0;
  int  cmds_sent = 0;
  int  replies_checked = 0;
  int  op_seen [8];
  int  stat_seen [4];
  int  idle_left = -1;
  bit  no_idle = 1'b0;
  bit  hold_next = 1'b0;

  logic [63:0] name_pool [POOL_SIZE];

  // Keep bytes up to the first zero byte, limited to NAME_BYTES.
  function automatic logic [63:0] trim_name(input logic [63:0] raw);
    logic [63:0] keep;
    int          n;
    keep = '0;
    n = 0;
    while (n < NAME_BYTES && raw[8*n +: 8] != 8'h00) begin
      keep[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return keep;
  endfunction

  // Scribble random bytes after the terminator; they must be ignored.
  function automatic logic [63:0] dress_name(input logic [63:0] n);
    logic [63:0] r;
    int          p;
    r = n;
    p = 0;
    while (p < 8 && n[8*p +: 8] != 8'h00) p++;
    for (int b = p + 1; b < 8; b++) begin
      if ($urandom_range(0, 1) == 1) r[8*b +: 8] = 8'($urandom());
    end
    return r;
  endfunction

  function automatic logic [63:0] make_name();
    logic [63:0] r;
    int          len;
    r = '0;
    len = $urandom_range(0, 8);
    for (int b = 0; b < len; b++) r[8*b +: 8] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  // Carry out one command on the shadow table and return its reply.
  function automatic dir_reply_t apply_command(input dir_cmd_t c);
    dir_reply_t  r;
    logic [63:0] nm;
    int          hit;
    int          free_at;
    nm = trim_name(c.name);
    r.status = STAT_NONE;
    r.slot = SLOT_NONE;
    r.value = '0;
    r.name = '0;
    r.in_use = 1'b0;
    hit = -1;
    free_at = -1;
    for (int i = DIR_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_used[i] && tbl_name[i] == nm) hit = i;
      if (!tbl_used[i]) free_at = i;
    end
    case (c.op)
      OP_FIND: begin
        r.value = VAL_NONE;
        if (hit >= 0) begin
          r.status = STAT_OK;
          r.slot = 5'(hit);
          r.value = {1'b0, tbl_sector[hit]};
        end
      end
      OP_ADD: begin
        if (hit >= 0) begin
          r.status = STAT_DUP;
          r.slot = 5'(hit);
        end else if (free_at < 0) begin
          r.status = STAT_FULL;
        end else begin
          tbl_used[free_at] = 1'b1;
          tbl_name[free_at] = nm;
          tbl_sector[free_at] = c.sector;
          tbl_link[free_at] = VAL_NONE;
          r.status = STAT_OK;
          r.slot = 5'(free_at);
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          r.status = STAT_OK;
          r.slot = 5'(hit);
        end
      end
      OP_SETLINK: begin
        if (hit >= 0) begin
          tbl_link[hit] = {1'b0, c.sector};
          r.status = STAT_OK;
          r.slot = 5'(hit);
        end
      end
      OP_GETLINK: begin
        r.value = VAL_NONE;
        if (hit >= 0) begin
          r.status = STAT_OK;
          r.slot = 5'(hit);
          r.value = tbl_link[hit];
        end
      end
      OP_READ: begin
        if (int'(c.index) < DIR_ENTRIES) begin
          r.slot = 5'(c.index);
          if (tbl_used[c.index]) begin
            r.status = STAT_OK;
            r.in_use = 1'b1;
            r.name = tbl_name[c.index];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [63:0] nm,
                           input logic [9:0] sec, input logic dir, input logic [3:0] idx);
    dir_cmd_t c;
    c.op = op;
    c.name = nm;
    c.sector = sec;
    c.isdir = dir;
    c.index = idx;
    c.idle = no_idle ? 0 : $urandom_range(0, 9);
    c.drain = hold_next;
    hold_next = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: a beat is taken when start is high and busy is low.
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      start <= 1'b0;
      idle_left = -1;
    end else begin
      if (start && !busy) begin
        awaited_replies.push_back(apply_command(cur_cmd));
        op_seen[cur_cmd.op]++;
        cmds_sent++;
      end
      if (!(start && busy)) begin
        go = 1'b0;
        if (pending_cmds.size() != 0) begin
          if (idle_left < 0) idle_left = pending_cmds[0].idle;
          if (idle_left > 0) idle_left--;
          else if (!pending_cmds[0].drain || awaited_replies.size() == 0) go = 1'b1;
        end
        if (go) begin
          cur_cmd = pending_cmds.pop_front();
          idle_left = -1;
          cmd <= cur_cmd.op;
          entry_name <= cur_cmd.name;
          sector_in <= cur_cmd.sector;
          is_directory <= cur_cmd.isdir;
          entry_index <= cur_cmd.index;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest outstanding reply.
  always @(posedge clk) begin
    dir_reply_t want;
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none outstanding: status %0d slot %0d", $time,
                 status, slot);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("slot", 64'(want.slot), 64'(slot));
        check_field("value", 64'(want.value), 64'(value));
        check_field("name_out", want.name, name_out);
        check_field("slot_in_use", 64'(want.in_use), 64'(slot_in_use));
        stat_seen[want.status]++;
        replies_checked++;
      end
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] n_max;
    logic [63:0] n_ab;
    logic [2:0]  op;
    int          r;
    int          add_top;
    int          rem_top;
    bit          filling;
    logic [63:0] nm;

    for (int i = 0; i < DIR_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_name[i] = '0;
      tbl_sector[i] = '0;
      tbl_link[i] = '0;
    end
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    for (int i = 0; i < 4; i++) stat_seen[i] = 0;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = make_name();

    n_max = '1;
    n_ab = 64'h0000_0000_0000_4241;

    // Directed: empty table, reserved opcodes, name forms, links, then fill up.
    no_idle = 1'b1;
    queue_cmd(OP_READ, '0, '0, 1'b0, 4'd15);
    queue_cmd(OP_FIND, n_ab, '0, 1'b0, '0);
    queue_cmd(OP_GETLINK, n_ab, '0, 1'b0, '0);
    queue_cmd(OP_REMOVE, n_ab, '0, 1'b0, '0);
    queue_cmd(OP_RSVD6, n_max, 10'h3FF, 1'b1, 4'hF);
    queue_cmd(OP_RSVD7, n_max, 10'h3FF, 1'b1, 4'hF);
    no_idle = 1'b0;
    queue_cmd(OP_ADD, n_max, 10'h3FF, 1'b1, '0);
    queue_cmd(OP_ADD, '0, '0, 1'b0, '0);
    queue_cmd(OP_ADD, 64'hA5C3_0F11_9900_4241, 10'd5, 1'b0, '0);
    queue_cmd(OP_FIND, 64'h1234_5678_0000_4241, '0, 1'b0, '0);
    queue_cmd(OP_ADD, n_ab, 10'd7, 1'b1, '0);
    queue_cmd(OP_GETLINK, n_ab, '0, 1'b0, '0);
    queue_cmd(OP_SETLINK, n_ab, 10'h3FF, 1'b0, '0);
    queue_cmd(OP_GETLINK, n_ab, '0, 1'b0, '0);
    queue_cmd(OP_READ, '0, '0, 1'b0, 4'd2);
    queue_cmd(OP_REMOVE, n_max, '0, 1'b0, '0);
    queue_cmd(OP_READ, '0, '0, 1'b0, 4'd0);
    for (int i = 0; i < DIR_ENTRIES - 1; i++) begin
      queue_cmd(OP_ADD, 64'h0000_0000_0000_7000 | 64'(i + 1), 10'(i), 1'(i), '0);
    end

    // Random: table swings between filling and draining phases.
    filling = 1'b0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 120 == 0) filling = !filling;
      if (n % 90 == 0) no_idle = 1'b1;
      if (n % 90 == 30) no_idle = 1'b0;
      if (n % 250 == 0) hold_next = 1'b1;
      r = $urandom_range(0, 99);
      add_top = filling ? 40 : 15;
      rem_top = add_top + (filling ? 10 : 30);
      if (r < add_top) op = OP_ADD;
      else if (r < rem_top) op = OP_REMOVE;
      else if (r < rem_top + 12) op = OP_FIND;
      else if (r < rem_top + 22) op = OP_SETLINK;
      else if (r < rem_top + 32) op = OP_GETLINK;
      else if (r < 97) op = OP_READ;
      else op = r[0] ? OP_RSVD6 : OP_RSVD7;
      if ($urandom_range(0, 9) == 0) nm = {$urandom(), $urandom()};
      else nm = dress_name(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
      queue_cmd(op, nm, 10'($urandom()), 1'($urandom()), 4'($urandom()));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Ran %0d commands: find %0d, add %0d, remove %0d, set link %0d, get link %0d,",
             cmds_sent, op_seen[OP_FIND], op_seen[OP_ADD], op_seen[OP_REMOVE],
             op_seen[OP_SETLINK], op_seen[OP_GETLINK]);
    $display("read %0d, reserved %0d; replies %0d: ok %0d, dup %0d, full %0d, miss %0d",
             op_seen[OP_READ], op_seen[OP_RSVD6] + op_seen[OP_RSVD7], replies_checked,
             stat_seen[STAT_OK], stat_seen[STAT_DUP], stat_seen[STAT_FULL],
             stat_seen[STAT_NONE]);
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ name_directory_table.f @@
design/ndt_pkg.sv
design/ndt_cell.sv
design/name_directory_table.sv
tb/sv/name_directory_table_test.sv
